// ===== rtl/isc_pkg.sv =====
// Shared types, codes and helpers for the inode handle cache.
// Used by isc_slot_ram, isc_ctrl and inode_handle_cache; depends on nothing.

package isc_pkg;

  localparam int SLOTS_DEFAULT    = 64;
  localparam int INODES_PER_BLOCK = 8;
  localparam int OFFSET_W         = $clog2(INODES_PER_BLOCK);
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // operation codes
  localparam logic [1:0] OP_GET  = 2'd0;
  localparam logic [1:0] OP_PUT  = 2'd1;
  localparam logic [1:0] OP_MARK = 2'd2;

  // result status codes
  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_LOADED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_STILL     = 3'd3;
  localparam logic [2:0] ST_CLEAN     = 3'd4;
  localparam logic [2:0] ST_WRITEBACK = 3'd5;
  localparam logic [2:0] ST_MARKED    = 3'd6;
  localparam logic [2:0] ST_BAD       = 3'd7;

  typedef struct packed {
    logic [3:0]  device;
    logic [23:0] inode;
    logic [15:0] count;
    logic        dirty;
  } entry_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [5:0]          slot;
    logic [31:0]         disk_block;
    logic [OFFSET_W-1:0] offset;
    logic [15:0]         count;
    logic [3:0]          device;
  } result_t;

  // block of the on-disk inode table that holds this inode (numbered from one)
  function automatic logic [31:0] inode_block(input logic [31:0] first_block,
                                              input logic [23:0] ino);
    logic [23:0] rel;
    rel = ino - 24'd1;
    return first_block + {{OFFSET_W{1'b0}}, 8'd0, rel[23:OFFSET_W]};
  endfunction

  function automatic logic [OFFSET_W-1:0] inode_offset(input logic [23:0] ino);
    logic [23:0] rel;
    rel = ino - 24'd1;
    return rel[OFFSET_W-1:0];
  endfunction

endpackage

// ===== rtl/isc_slot_ram.sv =====
// Slot table storage: one synchronous memory of slot entries plus valid flags.
// Depends on isc_pkg for entry_t.

module isc_slot_ram import isc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     re,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  entry_t                   wdata,
  output entry_t                   rdata,
  output logic                     rvalid
);

  entry_t             mem [SLOTS];
  logic [SLOTS-1:0]   valid;
  entry_t             rd_raw;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_raw <= mem[raddr];
    end
  end

  // every write claims or updates a live slot, so it marks the slot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= valid[raddr];
      end
    end
  end

  // a slot never written reads as empty
  assign rdata  = rd_vld ? rd_raw : '0;
  assign rvalid = rd_vld;

endmodule

// ===== rtl/isc_ctrl.sv =====
// Sequencer for get, put and mark-dirty: scans or reads the slot memory,
// updates the entry and builds the result. Depends on isc_pkg.

module isc_ctrl import isc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               op,
  input  logic [3:0]               device_id,
  input  logic [23:0]              inode_number,
  input  logic [5:0]               slot_index,
  input  logic [31:0]              first_block,
  input  logic                     out_free,
  output logic                     ram_re,
  output logic [$clog2(SLOTS)-1:0] ram_raddr,
  output logic                     ram_we,
  output logic [$clog2(SLOTS)-1:0] ram_waddr,
  output entry_t                   ram_wdata,
  input  entry_t                   ram_rdata,
  input  logic                     ram_rvalid,
  output result_t                  res,
  output logic                     res_valid
);

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RMW  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state, state_next;
  logic [1:0]    op_q, op_q_next;
  logic [3:0]    dev_q, dev_q_next;
  logic [23:0]   ino_q, ino_q_next;
  logic [SW-1:0] cidx, cidx_next;
  logic          free_found, free_found_next;
  logic [SW-1:0] free_idx, free_idx_next;
  result_t       res_next;

  logic          hit, is_free, slot_ok;
  logic [15:0]   cnt_dec;
  logic [SW-1:0] claim_idx;

  assign hit       = ram_rvalid && ram_rdata.device == dev_q && ram_rdata.inode == ino_q;
  assign is_free   = ram_rdata.count == 16'd0;
  assign slot_ok   = {26'd0, slot_index} < 32'(SLOTS);
  assign cnt_dec   = ram_rdata.count - 16'd1;
  assign claim_idx = free_found ? free_idx : cidx;

  always_comb begin
    state_next      = state;
    op_q_next       = op_q;
    dev_q_next      = dev_q;
    ino_q_next      = ino_q;
    cidx_next       = cidx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    res_next        = res;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    ram_we          = 1'b0;
    ram_waddr       = cidx;
    ram_wdata       = ram_rdata;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q_next       = op;
          dev_q_next      = device_id;
          ino_q_next      = inode_number;
          free_found_next = 1'b0;
          res_next        = '0;
          if (op == OP_GET) begin
            ram_re     = 1'b1;
            ram_raddr  = '0;
            cidx_next  = '0;
            state_next = S_SCAN;
          end else if ((op == OP_PUT || op == OP_MARK) && slot_ok) begin
            ram_re     = 1'b1;
            ram_raddr  = SW'(slot_index);
            cidx_next  = SW'(slot_index);
            state_next = S_RMW;
          end else begin
            res_next.status = ST_BAD;
            state_next      = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_next.slot   = 6'(cidx);
          res_next.device = ram_rdata.device;
          if (ram_rdata.count != COUNT_MAX) begin
            ram_we          = 1'b1;
            ram_wdata.count = ram_rdata.count + 16'd1;
            res_next.status = ST_HIT;
            res_next.count  = ram_rdata.count + 16'd1;
          end else begin
            res_next.status = ST_FULL;
            res_next.count  = ram_rdata.count;
          end
          state_next = S_DONE;
        end else if (cidx == LAST) begin
          if (free_found || is_free) begin
            ram_we              = 1'b1;
            ram_waddr           = claim_idx;
            ram_wdata.device    = dev_q;
            ram_wdata.inode     = ino_q;
            ram_wdata.count     = 16'd1;
            ram_wdata.dirty     = 1'b0;
            res_next.status     = ST_LOADED;
            res_next.slot       = 6'(claim_idx);
            res_next.count      = 16'd1;
            res_next.device     = dev_q;
            res_next.disk_block = inode_block(first_block, ino_q);
            res_next.offset     = inode_offset(ino_q);
          end else begin
            res_next.status = ST_FULL;
          end
          state_next = S_DONE;
        end else begin
          // remember the lowest free slot, keep sweeping for a match
          if (is_free && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = cidx;
          end
          ram_re    = 1'b1;
          ram_raddr = cidx + SW'(1);
          cidx_next = cidx + SW'(1);
        end
      end

      S_RMW: begin
        res_next.slot   = 6'(cidx);
        res_next.device = ram_rdata.device;
        res_next.count  = ram_rdata.count;
        if (is_free) begin
          res_next.status = ST_BAD;
        end else if (op_q == OP_PUT) begin
          ram_we          = 1'b1;
          ram_wdata.count = cnt_dec;
          res_next.count  = cnt_dec;
          if (cnt_dec != 16'd0) begin
            res_next.status = ST_STILL;
          end else if (ram_rdata.dirty) begin
            ram_wdata.dirty     = 1'b0;
            res_next.status     = ST_WRITEBACK;
            res_next.disk_block = inode_block(first_block, ram_rdata.inode);
            res_next.offset     = inode_offset(ram_rdata.inode);
          end else begin
            res_next.status = ST_CLEAN;
          end
        end else begin
          ram_we          = 1'b1;
          ram_wdata.dirty = 1'b1;
          res_next.status = ST_MARKED;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        // hold the result until the output register can take it
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_found <= 1'b0;
    end else begin
      state      <= state_next;
      free_found <= free_found_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_q_next;
    dev_q    <= dev_q_next;
    ino_q    <= ino_q_next;
    cidx     <= cidx_next;
    free_idx <= free_idx_next;
    res      <= res_next;
  end

  assign in_stall  = state != S_IDLE;
  assign res_valid = state == S_DONE;

endmodule

// ===== rtl/inode_handle_cache.sv =====
// Top level of the inode handle cache: config register, output register,
// slot memory and sequencer. Depends on isc_pkg, isc_slot_ram and isc_ctrl.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall     op, device_id, inode_number, slot_index
//   out       output     out_valid / out_stall   status, slot_out, disk_block,
//                                                block_offset, count_out, device_out
//   cfg       input      cfg_write               cfg_data (table_first_block)
//
// A get sweeps the slot memory one entry per cycle through its single read port,
// stopping at the first matching slot or, on a miss, after the last slot. Put and
// mark-dirty read the named slot, then go through modify-write, result and idle.
// A bad slot or op goes straight to the result.
// rst is synchronous and clears the valid flags, so the table starts empty at once.
// A stalled result waits in the output register; the next item is taken meanwhile.

module inode_handle_cache import isc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [3:0]  device_id,
  input  logic [23:0] inode_number,
  input  logic [5:0]  slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  slot_out,
  output logic [31:0] disk_block,
  output logic [2:0]  block_offset,
  output logic [15:0] count_out,
  output logic [3:0]  device_out,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data
);

  localparam int SW = $clog2(SLOTS);

  logic [31:0]   first_block;
  logic          out_free;
  logic          ram_re, ram_we, ram_rvalid;
  logic [SW-1:0] ram_raddr, ram_waddr;
  entry_t        ram_wdata, ram_rdata;
  result_t       res, out_res;
  logic          res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_block <= 32'd0;
    end else if (cfg_write) begin
      first_block <= cfg_data;
    end
  end

  isc_slot_ram #(.SLOTS(SLOTS)) u_ram (
    .clk    (clk),
    .rst    (rst),
    .re     (ram_re),
    .raddr  (ram_raddr),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .rdata  (ram_rdata),
    .rvalid (ram_rvalid)
  );

  isc_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .device_id    (device_id),
    .inode_number (inode_number),
    .slot_index   (slot_index),
    .first_block  (first_block),
    .out_free     (out_free),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_rdata    (ram_rdata),
    .ram_rvalid   (ram_rvalid),
    .res          (res),
    .res_valid    (res_valid)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res <= res;
    end
  end

  assign status       = out_res.status;
  assign slot_out     = out_res.slot;
  assign disk_block   = out_res.disk_block;
  assign block_offset = out_res.offset;
  assign count_out    = out_res.count;
  assign device_out   = out_res.device;

  // one transaction in flight: an accept closes the input until its result is out
  a_accept_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is still in flight");

  // memory updates only happen while a transaction is in flight
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> in_stall)
    else $error("slot memory written with no transaction in flight");

  a_result_moves: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_free) |=> (out_valid && !res_valid))
    else $error("finished result not moved to the output register");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_HIT || status == ST_STILL || status == ST_MARKED))
      |-> count_out != 16'd0)
    else $error("live slot reported with a zero reference count");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_LOADED) |-> count_out == 16'd1)
    else $error("claimed slot not reported with a single reference");

endmodule

// ===== tb/sv/inode_handle_cache_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for inode_handle_cache: directed table, fill/drain and
// random phases, scored against an in-file model of the slot table (fixed directed rows use hand answers).
// Depends on isc_pkg and the inode_handle_cache RTL.

module inode_handle_cache_test import isc_pkg::*;;

  localparam int NSLOTS = SLOTS_DEFAULT;
  localparam logic [1:0] OP_ILLEGAL = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam int POOL = 48;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [1:0]  opc;
    logic [3:0]  dev;
    logic [23:0] ino;
    logic [5:0]  idx;
    logic        fixed;
    result_t     want;
  } probe_t;

  // fixed rows hold the answer by hand; the rest are scored by the model
  localparam probe_t DIRECTED [20] = '{
    '{OP_PUT,     4'd0,  24'd0,       6'd0,  1'b1, '{ST_BAD, 6'd0, 32'h0, 3'd0, 16'd0, 4'd0}},
    '{OP_MARK,    4'd0,  24'd0,       6'd5,  1'b1, '{ST_BAD, 6'd5, 32'h0, 3'd0, 16'd0, 4'd0}},
    '{OP_ILLEGAL, 4'd15, 24'hFFFFFF,  6'd63, 1'b1, '{ST_BAD, 6'd0, 32'h0, 3'd0, 16'd0, 4'd0}},
    '{OP_GET,     4'd15, 24'hFFFFFF,  6'd0,  1'b1,
      '{ST_LOADED, 6'd0, 32'h001F_FFFF, 3'd6, 16'd1, 4'd15}},
    '{OP_GET,     4'd0,  24'd1,       6'd63, 1'b1, '{ST_LOADED, 6'd1, 32'h0, 3'd0, 16'd1, 4'd0}},
    '{OP_GET,     4'd3,  24'd0,       6'd0,  1'b1,
      '{ST_LOADED, 6'd2, 32'h001F_FFFF, 3'd7, 16'd1, 4'd3}},
    '{OP_GET,     4'd15, 24'hFFFFFF,  6'd0,  1'b1, '{ST_HIT, 6'd0, 32'h0, 3'd0, 16'd2, 4'd15}},
    '{OP_MARK,    4'd9,  24'h5A5A5A,  6'd0,  1'b1,
      '{ST_MARKED, 6'd0, 32'h0, 3'd0, 16'd2, 4'd15}},
    '{OP_PUT,     4'd0,  24'd0,       6'd0,  1'b0, '0},
    '{OP_PUT,     4'd0,  24'd0,       6'd0,  1'b0, '0},
    '{OP_PUT,     4'd0,  24'd0,       6'd0,  1'b1, '{ST_BAD, 6'd0, 32'h0, 3'd0, 16'd0, 4'd15}},
    '{OP_MARK,    4'd0,  24'd0,       6'd0,  1'b1, '{ST_BAD, 6'd0, 32'h0, 3'd0, 16'd0, 4'd15}},
    '{OP_GET,     4'd15, 24'hFFFFFF,  6'd0,  1'b0, '0},
    '{OP_PUT,     4'd0,  24'd0,       6'd1,  1'b0, '0},
    '{OP_GET,     4'd7,  24'd100,     6'd0,  1'b0, '0},
    '{OP_GET,     4'd14, 24'hFFFFFF,  6'd0,  1'b0, '0},
    '{OP_PUT,     4'd0,  24'd0,       6'd63, 1'b1, '{ST_BAD, 6'd63, 32'h0, 3'd0, 16'd0, 4'd0}},
    '{OP_MARK,    4'd0,  24'd0,       6'd63, 1'b1, '{ST_BAD, 6'd63, 32'h0, 3'd0, 16'd0, 4'd0}},
    '{OP_GET,     4'd0,  24'd1,       6'd0,  1'b0, '0},
    '{OP_GET,     4'd3,  24'd0,       6'd0,  1'b0, '0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = '0;
  logic [3:0]  device_id = '0;
  logic [23:0] inode_number = '0;
  logic [5:0]  slot_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  slot_out;
  logic [31:0] disk_block;
  logic [2:0]  block_offset;
  logic [15:0] count_out;
  logic [3:0]  device_out;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;

  // model of the slot table and the register
  logic [3:0]  tbl_dev   [NSLOTS] = '{default: '0};
  logic [23:0] tbl_ino   [NSLOTS] = '{default: '0};
  logic [15:0] tbl_refs  [NSLOTS] = '{default: '0};
  bit          tbl_dirty [NSLOTS] = '{default: 1'b0};
  bit          tbl_live  [NSLOTS] = '{default: 1'b0};
  logic [31:0] table_base = '0;

  logic [3:0]  pool_dev [POOL];
  logic [23:0] pool_ino [POOL];

  result_t awaited_results [$];
  int      mismatches = 0;
  bit      quiet = 1'b0;
  bit      hold_off_req = 1'b0;

  inode_handle_cache #(.SLOTS(NSLOTS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .device_id    (device_id),
    .inode_number (inode_number),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot_out     (slot_out),
    .disk_block   (disk_block),
    .block_offset (block_offset),
    .count_out    (count_out),
    .device_out   (device_out),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t slot_view(input int s, input logic [2:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.slot   = 6'(s);
    r.count  = tbl_refs[s];
    r.device = tbl_dev[s];
    return r;
  endfunction

  // inodes are numbered from one; zero wraps to the last position
  function automatic void locate_on_disk(inout result_t r, input logic [23:0] ino);
    logic [23:0] rel;
    rel = ino - 24'd1;
    r.disk_block = table_base + 32'(rel >> 3);
    r.offset     = rel[2:0];
  endfunction

  function automatic result_t predict_cache_reply(input logic [1:0] opc,
                                                  input logic [3:0] dev,
                                                  input logic [23:0] ino,
                                                  input logic [5:0] idx);
    result_t r;
    int hit_at;
    int free_at;
    r = '0;
    hit_at = -1;
    free_at = -1;
    if (opc == OP_GET) begin
      // scan downward so the lowest matching and lowest free slots win
      for (int s = NSLOTS - 1; s >= 0; s--) begin
        if (tbl_live[s] && tbl_dev[s] == dev && tbl_ino[s] == ino) hit_at = s;
        if (tbl_refs[s] == 16'd0) free_at = s;
      end
      if (hit_at >= 0) begin
        if (tbl_refs[hit_at] != COUNT_MAX) begin
          tbl_refs[hit_at] = tbl_refs[hit_at] + 16'd1;
          r = slot_view(hit_at, ST_HIT);
        end else begin
          r = slot_view(hit_at, ST_FULL);
        end
      end else if (free_at >= 0) begin
        tbl_live[free_at]  = 1'b1;
        tbl_dev[free_at]   = dev;
        tbl_ino[free_at]   = ino;
        tbl_refs[free_at]  = 16'd1;
        tbl_dirty[free_at] = 1'b0;
        r = slot_view(free_at, ST_LOADED);
        locate_on_disk(r, ino);
      end else begin
        r.status = ST_FULL;
      end
    end else if (opc == OP_ILLEGAL || int'(idx) >= NSLOTS) begin
      r.status = ST_BAD;
    end else if (opc == OP_PUT) begin
      if (tbl_refs[idx] == 16'd0) begin
        r = slot_view(idx, ST_BAD);
      end else begin
        tbl_refs[idx] = tbl_refs[idx] - 16'd1;
        if (tbl_refs[idx] != 16'd0) begin
          r = slot_view(idx, ST_STILL);
        end else if (tbl_dirty[idx]) begin
          tbl_dirty[idx] = 1'b0;
          r = slot_view(idx, ST_WRITEBACK);
          locate_on_disk(r, tbl_ino[idx]);
        end else begin
          r = slot_view(idx, ST_CLEAN);
        end
      end
    end else begin
      if (tbl_refs[idx] == 16'd0) begin
        r = slot_view(idx, ST_BAD);
      end else begin
        tbl_dirty[idx] = 1'b1;
        r = slot_view(idx, ST_MARKED);
      end
    end
    return r;
  endfunction

  function automatic logic [5:0] busy_slot();
    int n;
    int pick;
    n = 0;
    for (int s = 0; s < NSLOTS; s++) if (tbl_refs[s] != 16'd0) n++;
    if (n == 0) return 6'($urandom);
    pick = $urandom_range(0, n - 1);
    for (int s = 0; s < NSLOTS; s++) begin
      if (tbl_refs[s] != 16'd0) begin
        if (pick == 0) return 6'(s);
        pick--;
      end
    end
    return 6'd0;
  endfunction

  task automatic flag_mismatch(input string why, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected st=%0d slot=%0d blk=%h off=%0d cnt=%0d dev=%0d",
               $time, why, want.status, want.slot, want.disk_block, want.offset,
               want.count, want.device);
    if (mismatches <= 10)
      $display("           got      st=%0d slot=%0d blk=%h off=%0d cnt=%0d dev=%0d",
               got.status, got.slot, got.disk_block, got.offset, got.count, got.device);
  endtask

  // offer one transaction, hold it until accepted, then record its answer
  task automatic offer(input logic [1:0] opc, input logic [3:0] dev, input logic [23:0] ino,
                       input logic [5:0] idx, input bit fixed, input result_t want);
    int gap;
    result_t modeled;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= opc;
    device_id    <= dev;
    inode_number <= ino;
    slot_index   <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    modeled = predict_cache_reply(opc, dev, ino, idx);
    awaited_results.push_back(fixed ? want : modeled);
  endtask

  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      $display("[%0t] %0d results never arrived", $time, awaited_results.size());
      mismatches += awaited_results.size();
      awaited_results.delete();
    end
    // a miss sweeps the whole table
    repeat (NSLOTS + 8) @(posedge clk);
  endtask

  task automatic set_first_block(input logic [31:0] value);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write  <= 1'b0;
    table_base = value;
  endtask

  task automatic random_item(input int get_pct);
    int roll;
    int k;
    logic [1:0]  opc;
    logic [3:0]  dev;
    logic [23:0] ino;
    logic [5:0]  idx;
    roll = $urandom_range(0, 99);
    dev = 4'($urandom);
    ino = 24'($urandom);
    idx = 6'($urandom);
    if (roll < 3) begin
      opc = OP_ILLEGAL;
    end else if (roll < 3 + get_pct) begin
      opc = OP_GET;
      if ($urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, POOL - 1);
        dev = pool_dev[k];
        ino = pool_ino[k];
      end
    end else begin
      opc = ($urandom_range(0, 2) == 0) ? OP_MARK : OP_PUT;
      if ($urandom_range(0, 4) != 0) idx = busy_slot();
    end
    offer(opc, dev, ino, idx, 1'b0, '0);
  endtask

  initial begin : receiver
    int run;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // long hold-off: let the block back up into its input
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        run = idle_len() + 1;
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      got = '{status, slot_out, disk_block, block_offset, count_out, device_out};
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.disk_block !== want.disk_block || got.offset !== want.offset ||
            got.count !== want.count || got.device !== want.device)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    logic [31:0] phase_base [4];
    int get_share [4];
    phase_base = '{32'hFFFF_FFF8, $urandom(), 32'h0000_0000, 32'h7FFF_FFFF};
    get_share  = '{60, 35, 50, 70};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r])
      offer(DIRECTED[r].opc, DIRECTED[r].dev, DIRECTED[r].ino, DIRECTED[r].idx,
            DIRECTED[r].fixed, DIRECTED[r].want);

    // fill the table past capacity with fresh keys, then release every slot but 0
    set_first_block(32'hFFFF_FFFF);
    for (int i = 0; i < NSLOTS + 2; i++)
      offer(OP_GET, 4'(i), {8'(i), 16'($urandom)}, 6'($urandom), 1'b0, '0);
    for (int s = 1; s < NSLOTS; s++) begin
      if ($urandom_range(0, 1) == 0) offer(OP_MARK, 4'($urandom), 24'($urandom), 6'(s), 1'b0, '0);
      while (tbl_refs[s] != 16'd0)
        offer(OP_PUT, 4'($urandom), 24'($urandom), 6'(s), 1'b0, '0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      set_first_block(phase_base[ph]);
      for (int k = 0; k < POOL; k++) begin
        pool_dev[k] = 4'($urandom);
        pool_ino[k] = 24'($urandom);
      end
      pool_ino[0] = 24'd0;
      pool_ino[1] = 24'd1;
      pool_ino[2] = 24'hFFFFFF;
      quiet = (ph == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 30) hold_off_req = 1'b1;
        random_item(get_share[ph]);
      end
    end
    quiet = 1'b0;

    settle();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
